// ----- hw/rtl/can_frame_byte_statistics_defines.svh -----
// assertion helpers
`ifndef CAN_FRAME_BYTE_STATISTICS_DEFINES_SVH
`define CAN_FRAME_BYTE_STATISTICS_DEFINES_SVH
`define CFBS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CFBS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ----- hw/rtl/cfbs_pkg.sv -----
package cfbs_pkg;
    localparam int MAX_SLOTS_DEF = 32;
    localparam int MAX_BYTES_DEF = 8;
    localparam logic [2:0] ST_UPD   = 3'd0;
    localparam logic [2:0] ST_NEW   = 3'd1;
    localparam logic [2:0] ST_DROP  = 3'd2;
    localparam logic [2:0] ST_RDOK  = 3'd3;
    localparam logic [2:0] ST_RDEMP = 3'd4;
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic srch_step;
        logic alloc;
        logic upd_slot;
        logic byte_rd;
        logic byte_wr;
        logic out_rd;
        logic out_wr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic srch_hit;
        logic srch_end;
        logic full;
        logic bytes_done;
    } t_sts;
endpackage

// ----- hw/rtl/cfbs_ram.sv -----
module cfbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/cfbs_ctrl.sv -----
module cfbs_ctrl import cfbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_SWAIT = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BWAIT = 4'd6;
    localparam logic [3:0] S_BWR   = 4'd7;
    localparam logic [3:0] S_ORD   = 4'd8;
    localparam logic [3:0] S_OWAIT = 4'd9;
    localparam logic [3:0] S_OWR   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_sts.is_read) begin
                    n_state = S_ORD;
                end else if (i_sts.srch_end) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.srch_step = 1'b1;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (i_sts.srch_hit) n_state = S_DEC;
                else n_state = S_SRCH;
            end
            S_DEC: begin
                if (!i_sts.srch_hit && i_sts.full) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.alloc    = !i_sts.srch_hit;
                    o_cmd.upd_slot = 1'b1;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                if (i_sts.bytes_done) begin
                    n_state = S_ORD;
                end else begin
                    o_cmd.byte_rd = 1'b1;
                    n_state = S_BWAIT;
                end
            end
            S_BWAIT: n_state = S_BWR;
            S_BWR: begin
                o_cmd.byte_wr = 1'b1;
                n_state = S_BRD;
            end
            S_ORD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OWR;
            end
            S_OWR: begin
                o_cmd.out_wr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule

// ----- hw/rtl/cfbs_dp.sv -----
module cfbs_dp import cfbs_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_op,
    input  logic [28:0] i_can_id,
    input  logic [3:0]  i_dlc,
    input  logic [63:0] i_payload,
    input  logic [4:0]  i_slot_select,
    input  logic [2:0]  i_byte_select,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot_index,
    output logic [28:0] o_slot_id,
    output logic [3:0]  o_slot_length,
    output logic [31:0] o_slot_frames,
    output logic [31:0] o_all_frames,
    output logic [7:0]  o_byte_min,
    output logic [7:0]  o_byte_max,
    output logic [8:0]  o_byte_distinct,
    output logic [5:0]  o_slots_used
);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int BW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int NC = MAX_SLOTS * MAX_BYTES;
    localparam int AW = (NC > 1) ? $clog2(NC) : 1;
    localparam int MW = $clog2(NC * 256);
    localparam int SLW = 29 + 4 + 32;

    // slot memory: {id, len, count}
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic           slot_we;
    logic [SLW-1:0] slot_wdata, slot_rdata;
    logic           cell_we, seen_we;
    logic [AW-1:0]  cell_waddr, cell_raddr;
    logic [24:0]    cell_wdata, cell_rdata;
    logic [MW-1:0]  seen_waddr, seen_raddr, clr_seen;
    logic [0:0]     seen_wdata, seen_rdata;

    logic [MW:0]    r_clr;
    logic           r_op;
    logic [28:0]    r_id;
    logic [3:0]     r_len;
    logic [63:0]    r_pay;
    logic [4:0]     r_ssel;
    logic [2:0]     r_bsel;
    logic [CW-1:0]  r_used;
    logic [31:0]    r_total;
    logic [CW-1:0]  r_idx;
    logic           r_hit;
    logic [SW-1:0]  r_slot;
    logic           r_new;
    logic [3:0]     r_bi;
    logic [7:0]     r_bv;
    logic           r_slot_live;

    logic [3:0]     dlc_cl;
    logic           rd_ok;
    logic [7:0]     nmin, nmax;
    logic [8:0]     ndist;
    logic [7:0]     bv_now;

    assign dlc_cl = (i_dlc > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : i_dlc;
    assign rd_ok  = ({1'b0, r_ssel} < 6'(r_used)) && (32'(r_ssel) < 32'(MAX_SLOTS));
    assign bv_now = r_pay[8*r_bi[2:0] +: 8];
    assign clr_seen = r_clr[MW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.alloc) r_used <= r_used + 1'b1;
            if (i_cmd.upd_slot && r_total != '1) r_total <= r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_live <= i_cmd.srch_step;
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_id   <= i_can_id;
            r_len  <= dlc_cl;
            r_pay  <= i_payload;
            r_ssel <= i_slot_select;
            r_bsel <= i_byte_select;
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_new  <= 1'b0;
            r_bi   <= '0;
        end
        if (i_cmd.srch_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_slot_live && slot_rdata[SLW-1 -: 29] == r_id) begin
            r_hit  <= 1'b1;
            r_slot <= SW'(r_idx - 1'b1);
        end
        if (i_cmd.upd_slot && !r_hit) begin
            r_slot <= SW'(r_used);
            r_new  <= 1'b1;
        end
        if (i_cmd.byte_rd) r_bv <= bv_now;
        if (i_cmd.byte_wr) r_bi <= r_bi + 1'b1;
    end

    assign o_sts.clr_done   = (r_clr == MW'(NC * 256 - 1) + (MW+1)'(0)) ||
                              (r_clr[MW-1:0] == '1 && NC * 256 == (1 << MW));
    assign o_sts.is_read    = r_op;
    assign o_sts.srch_hit   = r_hit || (r_slot_live && slot_rdata[SLW-1 -: 29] == r_id);
    assign o_sts.srch_end   = (r_idx >= r_used);
    assign o_sts.full       = (r_used >= CW'(MAX_SLOTS));
    assign o_sts.bytes_done = (r_bi >= r_len);

    assign slot_we    = i_cmd.upd_slot;
    assign slot_waddr = r_hit ? r_slot : SW'(r_used);
    assign slot_wdata = r_hit ?
        {slot_rdata[SLW-1:32], (slot_rdata[31:0] == '1) ? slot_rdata[31:0]
                                                        : slot_rdata[31:0] + 32'd1} :
        {r_id, r_len, 32'd1};
    assign slot_raddr = i_cmd.out_rd ? (r_op ? SW'(r_ssel) : r_slot) :
                        (i_cmd.srch_step ? SW'(r_idx) :
                         (r_slot_live ? SW'(r_idx - 1'b1) : r_slot));

    cfbs_ram #(.WIDTH(SLW), .DEPTH(MAX_SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );

    // cell memory: {min, max, distinct}
    logic [AW-1:0] cell_addr_b;
    assign cell_addr_b = AW'(32'(r_slot) * MAX_BYTES + 32'(r_bi));
    assign cell_raddr  = i_cmd.out_rd ?
        AW'(32'(r_op ? SW'(r_ssel) : r_slot) * MAX_BYTES + 32'(r_bsel)) : cell_addr_b;
    assign seen_raddr  = MW'({cell_addr_b, bv_now});

    logic [7:0] cmin, cmax;
    logic [8:0] cdist;
    logic       seen_b;
    assign cmin   = cell_rdata[24:17];
    assign cmax   = cell_rdata[16:9];
    assign cdist  = cell_rdata[8:0];
    assign seen_b = seen_rdata[0];
    assign nmin   = (r_bv < cmin) ? r_bv : cmin;
    assign nmax   = (r_bv > cmax) ? r_bv : cmax;
    assign ndist  = seen_b ? cdist : cdist + 9'd1;

    assign cell_we    = i_cmd.clr_step ? ({1'b0, r_clr[MW-1:8]} < (MW-7)'(NC))
                                       : i_cmd.byte_wr;
    assign cell_waddr = i_cmd.clr_step ? AW'(r_clr[MW-1:8]) : cell_addr_b;
    assign cell_wdata = i_cmd.clr_step ? {8'hFF, 8'h00, 9'd0} : {nmin, nmax, ndist};
    assign seen_we    = i_cmd.clr_step || i_cmd.byte_wr;
    assign seen_waddr = i_cmd.clr_step ? clr_seen : MW'({cell_addr_b, r_bv});
    assign seen_wdata = i_cmd.clr_step ? 1'b0 : 1'b1;

    cfbs_ram #(.WIDTH(25), .DEPTH(NC)) u_cell (
        .i_clk(i_clk), .i_we(cell_we), .i_waddr(cell_waddr), .i_wdata(cell_wdata),
        .i_raddr(cell_raddr), .o_rdata(cell_rdata)
    );
    cfbs_ram #(.WIDTH(1), .DEPTH(NC * 256)) u_seen (
        .i_clk(i_clk), .i_we(seen_we), .i_waddr(seen_waddr), .i_wdata(seen_wdata),
        .i_raddr(seen_raddr), .o_rdata(seen_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            o_all_frames <= r_total;
            o_slots_used <= 6'(r_used);
            if (r_op == OP_READ) begin
                o_slot_index <= r_ssel;
                o_status     <= rd_ok ? ST_RDOK : ST_RDEMP;
            end else begin
                o_slot_index <= 5'(r_slot);
                o_status     <= r_new ? ST_NEW : ST_UPD;
            end
            if (r_op == OP_ADD || rd_ok) begin
                o_slot_id     <= slot_rdata[SLW-1 -: 29];
                o_slot_length <= slot_rdata[35:32];
                o_slot_frames <= slot_rdata[31:0];
                if (32'(r_bsel) < MAX_BYTES) begin
                    o_byte_min      <= cmin;
                    o_byte_max      <= cmax;
                    o_byte_distinct <= cdist;
                end else begin
                    o_byte_min      <= 8'hFF;
                    o_byte_max      <= 8'h00;
                    o_byte_distinct <= 9'd0;
                end
            end else begin
                o_slot_id       <= '0;
                o_slot_length   <= '0;
                o_slot_frames   <= '0;
                o_byte_min      <= '0;
                o_byte_max      <= '0;
                o_byte_distinct <= '0;
            end
        end
        if (i_cmd.load) begin
            o_status        <= ST_DROP;
            o_slot_index    <= '0;
            o_slot_id       <= '0;
            o_slot_length   <= '0;
            o_slot_frames   <= '0;
            o_byte_min      <= '0;
            o_byte_max      <= '0;
            o_byte_distinct <= '0;
            o_all_frames    <= r_total;
            o_slots_used    <= 6'(r_used);
        end
    end
endmodule

// ----- hw/rtl/can_frame_byte_statistics.sv -----
// An add compares the stored slots in turn and takes a new slot if none matches
// (or drops the frame if all slots are taken), then updates the cells of its bytes.
// One item at a time: the next beat is accepted the cycle after the result is taken.
// Result is held in an output register until taken.
// Reset (synchronous, active low) starts a clearing pass over the seen-value RAM
// and the byte-cell RAM; no item is accepted meanwhile.
module can_frame_byte_statistics import cfbs_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [28:0] i_can_id,
    input  logic [3:0]  i_dlc,
    input  logic [63:0] i_payload,
    input  logic [4:0]  i_slot_select,
    input  logic [2:0]  i_byte_select,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot_index,
    output logic [28:0] o_slot_id,
    output logic [3:0]  o_slot_length,
    output logic [31:0] o_slot_frames,
    output logic [31:0] o_all_frames,
    output logic [7:0]  o_byte_min,
    output logic [7:0]  o_byte_max,
    output logic [8:0]  o_byte_distinct,
    output logic [5:0]  o_slots_used
);
    t_cmd cmd;
    t_sts sts;

    cfbs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_sts(sts), .o_cmd(cmd)
    );

    cfbs_dp #(.MAX_SLOTS(MAX_SLOTS), .MAX_BYTES(MAX_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_op(i_op), .i_can_id(i_can_id), .i_dlc(i_dlc), .i_payload(i_payload),
        .i_slot_select(i_slot_select), .i_byte_select(i_byte_select),
        .o_status(o_status), .o_slot_index(o_slot_index), .o_slot_id(o_slot_id),
        .o_slot_length(o_slot_length), .o_slot_frames(o_slot_frames),
        .o_all_frames(o_all_frames), .o_byte_min(o_byte_min), .o_byte_max(o_byte_max),
        .o_byte_distinct(o_byte_distinct), .o_slots_used(o_slots_used)
    );
endmodule

// ----- hw/rtl/cfbs_checker.sv -----
`include "can_frame_byte_statistics_defines.svh"
module cfbs_checker import cfbs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input logic [5:0] o_slots_used
);
    `CFBS_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, o_valid, o_stall)
    `CFBS_ASSERT_IMP(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_RDEMP)
    `CFBS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
    `CFBS_ASSERT_IMP(a_new_used, i_clk, i_rst_n, o_valid && o_status == ST_NEW,
                     o_slots_used != 6'd0)
endmodule

bind can_frame_byte_statistics cfbs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status), .o_slots_used(o_slots_used)
);
